// ===== rtl/llhb_pkg.sv =====
// ----------------------------------------------------------------------------
// llhb_pkg
// Shared constants and types of the length-limited Huffman code builder.
// ----------------------------------------------------------------------------
`default_nettype none

package llhb_pkg;

  localparam int NSYM    = 256;
  localparam int SYM_W   = 8;
  localparam int CNT_W   = 32;
  localparam int LEN_W   = 5;
  localparam int CODE_W  = 16;
  localparam int MAXL    = 16;
  localparam int WGT_W   = 40;
  localparam int LNK_W   = 9;
  localparam int IDX_W   = 9;
  localparam int LVL_W   = 4;
  localparam int NSYM_W  = 9;
  localparam int CFG_W   = 9;

  localparam logic [1:0] OP_COUNT = 2'd0;
  localparam logic [1:0] OP_BUILD = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic CFG_NUM_SYM = 1'b0;
  localparam logic CFG_MAX_LEN = 1'b1;

  localparam logic KIND_BUILD = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // One entry of a package-merge level list.
  typedef struct packed {
    logic [WGT_W-1:0] w;
    logic [LNK_W-1:0] link;
    logic             leaf;
  } lvl_item_t;

  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_CNT    = 18'h00002,
    S_RDOUT  = 18'h00004,
    S_RKRD   = 18'h00008,
    S_RKGET  = 18'h00010,
    S_RKSCAN = 18'h00020,
    S_CHECK  = 18'h00040,
    S_MGINIT = 18'h00080,
    S_MGRD   = 18'h00100,
    S_MGWR   = 18'h00200,
    S_EXINIT = 18'h00400,
    S_EXLEV  = 18'h00800,
    S_EXRD   = 18'h01000,
    S_EXGET  = 18'h02000,
    S_EXINC  = 18'h04000,
    S_CARD   = 18'h08000,
    S_CAGET  = 18'h10000,
    S_FIN    = 18'h20000
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/length_limited_huffman_builder_core.sv =====
// ----------------------------------------------------------------------------
// length_limited_huffman_builder_core
// Symbol histogram with a package-merge builder of length-limited canonical
// Huffman codes, run by a small sequencer over memories with one read port each.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Payload
//  in       input      in_valid / in_ready   opcode, symbol
//  out      output     out_valid / out_ready result_kind, code_bits,
//                                            code_length, build_error
//  cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A count request reads and then writes the histogram entry; a read request
// reads the length and code of its symbol and may wait on the output register.
// A build runs a stable rank sort, a merge of the level lists, an expansion
// of the lists into code lengths and a canonical code assignment; the single
// read port of each memory sets how these steps are split. The input is not
// ready while a request is in work. Reset clears the histogram, lengths and
// codes at once through valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module length_limited_huffman_builder_core
  import llhb_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        opcode_i,
  input  wire logic [SYM_W-1:0]  symbol_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   result_kind_o,
  output logic      [CODE_W-1:0] code_bits_o,
  output logic      [LEN_W-1:0]  code_length_o,
  output logic                   build_error_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic              cfg_index_i,
  input  wire logic [CFG_W-1:0]  cfg_data_i
);

  state_e state_q, state_d;

  logic [NSYM_W-1:0] num_sym_q, num_sym_d;
  logic [LEN_W-1:0]  max_len_q, max_len_d;
  logic [NSYM_W-1:0] ns;
  logic [LEN_W-1:0]  lim;

  logic [SYM_W-1:0]  sym_q, sym_d;
  logic [IDX_W-1:0]  i_q, i_d, j_q, j_d, jd_q, jd_d;
  logic              pend_q, pend_d;
  logic [CNT_W-1:0]  ci_q, ci_d;
  logic [SYM_W-1:0]  rank_q, rank_d;
  logic [IDX_W-1:0]  n_q, n_d;
  logic [LEN_W-1:0]  lev_q, lev_d;
  logic [IDX_W-1:0]  a_q, a_d, o_q, o_d, take_q, take_d;
  logic [SYM_W-1:0]  b_q, b_d, pairs_q, pairs_d, pk_q, pk_d, s_q, s_d;
  logic [LEN_W-1:0]  ca_q, ca_d;
  logic [MAXL:0]     off_q, off_d;
  logic              err_q, err_d;

  logic [IDX_W-1:0]  lsz_q [MAXL];
  logic              lsz_we;
  logic [LVL_W-1:0]  lsz_waddr;
  logic [IDX_W-1:0]  lsz_wdata;
  logic [LEN_W-1:0]  levm1;
  logic [IDX_W-1:0]  lsz_rd;

  logic              out_valid_q, out_valid_d;
  logic              kind_q, kind_d;
  logic [CODE_W-1:0] code_q, code_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              berr_q, berr_d;
  logic              out_free;

  // Memory ports.
  logic              cnt_we, cnt_rvld;
  logic [SYM_W-1:0]  cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]  cnt_wdata, cnt_rdata, cnt_val;
  logic              len_clr, len_we, len_rvld;
  logic [SYM_W-1:0]  len_waddr, len_raddr;
  logic [LEN_W-1:0]  len_wdata, len_rdata, len_val;
  logic              cod_we, cod_rvld;
  logic [SYM_W-1:0]  cod_waddr, cod_raddr;
  logic [CODE_W-1:0] cod_wdata, cod_rdata;
  logic              leaf_we;
  logic [CNT_W+SYM_W-1:0] leaf_wdata, leaf_rdata;
  logic [CNT_W-1:0]  leaf_w;
  logic [SYM_W-1:0]  leaf_sym;
  logic              lvl_we;
  logic [LVL_W+IDX_W-1:0] lvl_waddr, lvla_raddr, lvlb_raddr;
  lvl_item_t         lvl_wdata, lvla_rd, lvlb_rd;

  logic [WGT_W-1:0]  pw;
  logic              take_leaf;
  logic [LVL_W-1:0]  sh;
  logic [MAXL:0]     acode;
  logic [CODE_W-1:0] rev;
  logic [IDX_W:0]    twice_n;

  function automatic logic [CODE_W-1:0] bitrev(input logic [CODE_W-1:0] v);
    logic [CODE_W-1:0] r;
    for (int k = 0; k < CODE_W; k++) begin
      r[k] = v[CODE_W-1-k];
    end
    return r;
  endfunction

  assign ns  = (num_sym_q > NSYM_W'(NSYM)) ? NSYM_W'(NSYM) : num_sym_q;
  assign lim = (max_len_q == '0) ? LEN_W'(1) :
               (max_len_q > LEN_W'(MAXL)) ? LEN_W'(MAXL) : max_len_q;

  assign cnt_val  = cnt_rvld ? cnt_rdata : '0;
  assign len_val  = len_rvld ? len_rdata : '0;
  assign leaf_w   = leaf_rdata[CNT_W+SYM_W-1:SYM_W];
  assign leaf_sym = leaf_rdata[SYM_W-1:0];
  assign levm1    = lev_q - LEN_W'(1);
  assign lsz_rd   = lsz_q[levm1[LVL_W-1:0]];
  assign out_free = !out_valid_q || out_ready_i;

  // Shared merge adder and compare.
  assign pw        = (b_q < pairs_q) ? (lvla_rd.w + lvlb_rd.w) : '0;
  assign take_leaf = (a_q < n_q) &&
                     ((b_q >= pairs_q) || ({{(WGT_W-CNT_W){1'b0}}, leaf_w} <= pw));

  // Shared shift unit for canonical code assignment.
  assign sh    = LVL_W'(lim - ca_q);
  assign acode = off_q >> sh;
  assign rev   = bitrev(acode[CODE_W-1:0]) >> (LEN_W'(CODE_W) - ca_q);
  assign twice_n = {n_q, 1'b0} - (IDX_W+1)'(2);

  always_comb begin
    cnt_raddr = j_q[SYM_W-1:0];
    len_raddr = j_q[SYM_W-1:0];
    cod_raddr = sym_q;
    lvla_raddr = {lev_q[LVL_W-1:0], j_q};
    unique case (state_q)
      S_IDLE: begin
        cnt_raddr = symbol_i;
        len_raddr = symbol_i;
        cod_raddr = symbol_i;
      end
      S_RDOUT:  len_raddr  = sym_q;
      S_RKRD:   cnt_raddr  = i_q[SYM_W-1:0];
      S_EXGET:  len_raddr  = lvla_rd.link[SYM_W-1:0];
      S_MGRD:   lvla_raddr = {levm1[LVL_W-1:0], b_q, 1'b0};
      default: ;
    endcase
  end
  assign lvlb_raddr = {levm1[LVL_W-1:0], b_q, 1'b1};

  always_comb begin
    state_d = state_q;
    sym_d = sym_q; i_d = i_q; j_d = j_q; jd_d = jd_q; pend_d = pend_q;
    ci_d = ci_q; rank_d = rank_q; n_d = n_q; lev_d = lev_q;
    a_d = a_q; b_d = b_q; o_d = o_q; pairs_d = pairs_q;
    take_d = take_q; pk_d = pk_q; s_d = s_q; ca_d = ca_q;
    off_d = off_q; err_d = err_q;
    num_sym_d = num_sym_q; max_len_d = max_len_q;
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d = kind_q; code_d = code_q; len_d = len_q; berr_d = berr_q;
    lsz_we = 1'b0; lsz_waddr = '0; lsz_wdata = o_q;
    cnt_we = 1'b0; cnt_waddr = sym_q; cnt_wdata = cnt_val + CNT_W'(1);
    len_clr = 1'b0; len_we = 1'b0; len_waddr = s_q;
    len_wdata = len_val + LEN_W'(1);
    cod_we = 1'b0; cod_waddr = j_q[SYM_W-1:0]; cod_wdata = rev;
    leaf_we = 1'b0; leaf_wdata = {ci_q, i_q[SYM_W-1:0]};
    lvl_we = 1'b0;
    lvl_waddr = {lev_q[LVL_W-1:0], o_q};
    lvl_wdata.w = {{(WGT_W-CNT_W){1'b0}}, ci_q};
    lvl_wdata.link = {1'b0, i_q[SYM_W-1:0]};
    lvl_wdata.leaf = 1'b1;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_NUM_SYM: num_sym_d = cfg_data_i[NSYM_W-1:0];
        CFG_MAX_LEN: max_len_d = cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        sym_d = symbol_i;
        if (in_valid_i) begin
          unique case (opcode_i)
            OP_COUNT: if ({1'b0, symbol_i} < ns) state_d = S_CNT;
            OP_BUILD: begin
              len_clr = 1'b1;
              i_d = '0;
              n_d = '0;
              state_d = S_RKRD;
            end
            OP_READ: state_d = S_RDOUT;
            default: ;
          endcase
        end
      end
      S_CNT: begin
        // Saturating count.
        cnt_we  = (cnt_val != '1);
        state_d = S_IDLE;
      end
      S_RDOUT: if (out_free) begin
        out_valid_d = 1'b1;
        kind_d = KIND_READ;
        code_d = cod_rvld ? cod_rdata : {{(CODE_W-SYM_W){1'b0}}, sym_q};
        len_d  = len_val;
        berr_d = 1'b0;
        state_d = S_IDLE;
      end
      S_RKRD: begin
        if (i_q == ns) begin
          state_d = S_CHECK;
        end else begin
          state_d = S_RKGET;
        end
      end
      S_RKGET: begin
        ci_d = cnt_val;
        if (cnt_val == '0) begin
          i_d = i_q + IDX_W'(1);
          state_d = S_RKRD;
        end else begin
          j_d = '0;
          rank_d = '0;
          pend_d = 1'b0;
          state_d = S_RKSCAN;
        end
      end
      S_RKSCAN: begin
        // The rank of a symbol is the number of used symbols sorted ahead.
        if (pend_q && cnt_val != '0 &&
            (cnt_val < ci_q || (cnt_val == ci_q && jd_q < i_q))) begin
          rank_d = rank_q + SYM_W'(1);
        end
        if (j_q != ns) begin
          pend_d = 1'b1;
          jd_d = j_q;
          j_d = j_q + IDX_W'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            leaf_we = 1'b1;
            lvl_we = 1'b1;
            lvl_waddr = {{LVL_W{1'b0}}, 1'b0, rank_q};
            n_d = n_q + IDX_W'(1);
            i_d = i_q + IDX_W'(1);
            state_d = S_RKRD;
          end
        end
      end
      S_CHECK: begin
        err_d = 1'b0;
        if (n_q == '0) begin
          state_d = S_FIN;
        end else if ({{(MAXL+1-IDX_W){1'b0}}, n_q} > ((MAXL+1)'(1) << lim)) begin
          err_d = 1'b1;
          state_d = S_FIN;
        end else begin
          lsz_we = 1'b1;
          lsz_waddr = '0;
          lsz_wdata = n_q;
          lev_d = LEN_W'(1);
          state_d = S_MGINIT;
        end
      end
      S_MGINIT: begin
        if (lev_q == lim) begin
          state_d = S_EXINIT;
        end else begin
          pairs_d = lsz_rd[IDX_W-1:1];
          a_d = '0;
          b_d = '0;
          o_d = '0;
          state_d = S_MGRD;
        end
      end
      S_MGRD: begin
        if (a_q < n_q || b_q < pairs_q) begin
          state_d = S_MGWR;
        end else begin
          lsz_we = 1'b1;
          lsz_waddr = lev_q[LVL_W-1:0];
          lsz_wdata = o_q;
          lev_d = lev_q + LEN_W'(1);
          state_d = S_MGINIT;
        end
      end
      S_MGWR: begin
        lvl_we = 1'b1;
        if (take_leaf) begin
          lvl_wdata.w = {{(WGT_W-CNT_W){1'b0}}, leaf_w};
          lvl_wdata.link = {1'b0, leaf_sym};
          lvl_wdata.leaf = 1'b1;
          a_d = a_q + IDX_W'(1);
        end else begin
          lvl_wdata.w = pw;
          lvl_wdata.link = {b_q, 1'b0};
          lvl_wdata.leaf = 1'b0;
          b_d = b_q + SYM_W'(1);
        end
        o_d = o_q + IDX_W'(1);
        state_d = S_MGRD;
      end
      S_EXINIT: begin
        lev_d = lim;
        take_d = twice_n[IDX_W-1:0];
        state_d = S_EXLEV;
      end
      S_EXLEV: begin
        if (lev_q == '0) begin
          ca_d = LEN_W'(1);
          j_d = '0;
          off_d = '0;
          state_d = S_CARD;
        end else begin
          lev_d = levm1;
          take_d = (take_q > lsz_rd) ? lsz_rd : take_q;
          j_d = '0;
          pk_d = '0;
          state_d = S_EXRD;
        end
      end
      S_EXRD: begin
        if (j_q == take_q) begin
          take_d = {pk_q, 1'b0};
          state_d = S_EXLEV;
        end else begin
          state_d = S_EXGET;
        end
      end
      S_EXGET: begin
        if (lvla_rd.leaf) begin
          s_d = lvla_rd.link[SYM_W-1:0];
          state_d = S_EXINC;
        end else begin
          pk_d = pk_q + SYM_W'(1);
          j_d = j_q + IDX_W'(1);
          state_d = S_EXRD;
        end
      end
      S_EXINC: begin
        len_we = 1'b1;
        j_d = j_q + IDX_W'(1);
        state_d = S_EXRD;
      end
      S_CARD: begin
        if (j_q == ns) begin
          if (ca_q == lim) begin
            state_d = S_FIN;
          end else begin
            ca_d = ca_q + LEN_W'(1);
            j_d = '0;
          end
        end else begin
          state_d = S_CAGET;
        end
      end
      S_CAGET: begin
        if (len_val == ca_q) begin
          cod_we = 1'b1;
          off_d = off_q + ((MAXL+1)'(1) << sh);
        end
        j_d = j_q + IDX_W'(1);
        state_d = S_CARD;
      end
      S_FIN: if (out_free) begin
        // An error build leaves every length cleared, as set at its start.
        out_valid_d = 1'b1;
        kind_d = KIND_BUILD;
        code_d = '0;
        len_d = '0;
        berr_d = err_q;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      num_sym_q   <= NSYM_W'(256);
      max_len_q   <= LEN_W'(15);
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      off_q       <= '0;
      err_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      num_sym_q   <= num_sym_d;
      max_len_q   <= max_len_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      off_q       <= off_d;
      err_q       <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d; i_q <= i_d; j_q <= j_d; jd_q <= jd_d;
    ci_q <= ci_d; rank_q <= rank_d; n_q <= n_d; lev_q <= lev_d;
    a_q <= a_d; b_q <= b_d; o_q <= o_d; pairs_q <= pairs_d;
    take_q <= take_d; pk_q <= pk_d; s_q <= s_d; ca_q <= ca_d;
    kind_q <= kind_d; code_q <= code_d; len_q <= len_d; berr_q <= berr_d;
    if (lsz_we) begin
      lsz_q[lsz_waddr] <= lsz_wdata;
    end
  end

  llhb_vram #(.W(CNT_W), .DEPTH(NSYM)) u_cnt (
    .clk_i, .rst_ni, .clr_i(1'b0), .we_i(cnt_we), .waddr_i(cnt_waddr),
    .wdata_i(cnt_wdata), .raddr_i(cnt_raddr), .rdata_o(cnt_rdata),
    .rvalid_o(cnt_rvld)
  );

  llhb_vram #(.W(LEN_W), .DEPTH(NSYM)) u_len (
    .clk_i, .rst_ni, .clr_i(len_clr), .we_i(len_we), .waddr_i(len_waddr),
    .wdata_i(len_wdata), .raddr_i(len_raddr), .rdata_o(len_rdata),
    .rvalid_o(len_rvld)
  );

  llhb_vram #(.W(CODE_W), .DEPTH(NSYM)) u_code (
    .clk_i, .rst_ni, .clr_i(1'b0), .we_i(cod_we), .waddr_i(cod_waddr),
    .wdata_i(cod_wdata), .raddr_i(cod_raddr), .rdata_o(cod_rdata),
    .rvalid_o(cod_rvld)
  );

  llhb_ram #(.W(CNT_W+SYM_W), .DEPTH(NSYM)) u_leaf (
    .clk_i, .we_i(leaf_we), .waddr_i(rank_q), .wdata_i(leaf_wdata),
    .raddr_i(a_q[SYM_W-1:0]), .rdata_o(leaf_rdata)
  );

  // Two copies of the level lists give two read ports for pair sums.
  llhb_ram #(.W($bits(lvl_item_t)), .DEPTH(MAXL*2*NSYM)) u_lvl_a (
    .clk_i, .we_i(lvl_we), .waddr_i(lvl_waddr), .wdata_i(lvl_wdata),
    .raddr_i(lvla_raddr), .rdata_o(lvla_rd)
  );

  llhb_ram #(.W($bits(lvl_item_t)), .DEPTH(MAXL*2*NSYM)) u_lvl_b (
    .clk_i, .we_i(lvl_we), .waddr_i(lvl_waddr), .wdata_i(lvl_wdata),
    .raddr_i(lvlb_raddr), .rdata_o(lvlb_rd)
  );

  assign in_ready_o    = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign code_bits_o   = code_q;
  assign code_length_o = len_q;
  assign build_error_o = berr_q;

endmodule

`default_nettype wire

// ===== rtl/llhb_ram.sv =====
// ----------------------------------------------------------------------------
// llhb_ram
// Simple memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module llhb_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [W-1:0]  wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/llhb_vram.sv =====
// ----------------------------------------------------------------------------
// llhb_vram
// Memory with one valid flag per entry, cleared at reset or on request.
// ----------------------------------------------------------------------------
`default_nettype none

module llhb_vram #(
  parameter int W     = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          clr_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [W-1:0]  wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [W-1:0]  rdata_o,
  output logic               rvalid_o
);

  logic [W-1:0]     mem_q [DEPTH];
  logic [W-1:0]     rdata_q;
  logic [DEPTH-1:0] vld_q;
  logic             rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (clr_i) begin
        vld_q <= '0;
      end else if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rvalid_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o  = rdata_q;
  assign rvalid_o = rvalid_q;

endmodule

`default_nettype wire
